// ===== src/ubx_fb_pkg.sv =====
`default_nettype none
package ubx_fb_pkg;

  // Sync characters that open every frame.
  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  // Longest burst one item can cause: six header bytes plus two checksum bytes.
  localparam int unsigned BURST_MAX = 8;
  localparam int unsigned IDX_W     = $clog2(BURST_MAX);

  // Item operation codes.
  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  // The output bytes that one accepted item causes.
  typedef struct packed {
    logic                            emits;
    logic [BURST_MAX-1:0][7:0]       bytes;
    logic [IDX_W-1:0]                last_idx;
    logic                            frame_end;
  } burst_t;

endpackage
`default_nettype wire

// ===== src/ubx_fb_frame_gen.sv =====
`default_nettype none
module ubx_fb_frame_gen (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              op_i,
  input  wire logic [7:0]        msg_class_i,
  input  wire logic [7:0]        msg_ident_i,
  input  wire logic [15:0]       payload_len_i,
  input  wire logic [7:0]        data_byte_i,
  output ubx_fb_pkg::burst_t     burst_o
);

  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [15:0] left_q, left_d;
  logic        in_frame_q, in_frame_d;

  // Running sums over the four summed header bytes.
  logic [7:0] ha1, ha2, ha3, ha4;
  logic [7:0] hb2, hb3, hb4;
  // Running sums after one payload byte.
  logic [7:0] pa, pb;
  logic [15:0] left_dec;

  assign ha1 = msg_class_i;
  assign ha2 = ha1 + msg_ident_i;
  assign hb2 = ha1 + ha2;
  assign ha3 = ha2 + payload_len_i[7:0];
  assign hb3 = hb2 + ha3;
  assign ha4 = ha3 + payload_len_i[15:8];
  assign hb4 = hb3 + ha4;

  assign pa       = sum_a_q + data_byte_i;
  assign pb       = sum_b_q + pa;
  assign left_dec = left_q - 16'd1;

  // Form the burst and the next frame state for the item on the input.
  always_comb begin
    burst_o    = '0;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    left_d     = left_q;
    in_frame_d = in_frame_q;
    case (ubx_fb_pkg::op_e'(op_i))
      ubx_fb_pkg::OP_START: begin
        burst_o.emits    = 1'b1;
        burst_o.bytes[0] = ubx_fb_pkg::SYNC_ONE;
        burst_o.bytes[1] = ubx_fb_pkg::SYNC_TWO;
        burst_o.bytes[2] = msg_class_i;
        burst_o.bytes[3] = msg_ident_i;
        burst_o.bytes[4] = payload_len_i[7:0];
        burst_o.bytes[5] = payload_len_i[15:8];
        burst_o.bytes[6] = ha4;
        burst_o.bytes[7] = hb4;
        sum_a_d          = ha4;
        sum_b_d          = hb4;
        if (payload_len_i == 16'd0) begin
          burst_o.last_idx  = ubx_fb_pkg::IDX_W'(ubx_fb_pkg::BURST_MAX - 1);
          burst_o.frame_end = 1'b1;
          left_d            = 16'd0;
          in_frame_d        = 1'b0;
        end else begin
          burst_o.last_idx  = ubx_fb_pkg::IDX_W'(ubx_fb_pkg::BURST_MAX - 3);
          left_d            = payload_len_i;
          in_frame_d        = 1'b1;
        end
      end
      ubx_fb_pkg::OP_PAYLOAD: begin
        // A payload item outside a frame causes nothing.
        if (in_frame_q) begin
          burst_o.emits    = 1'b1;
          burst_o.bytes[0] = data_byte_i;
          burst_o.bytes[1] = pa;
          burst_o.bytes[2] = pb;
          sum_a_d          = pa;
          sum_b_d          = pb;
          if (left_dec == 16'd0) begin
            burst_o.last_idx  = ubx_fb_pkg::IDX_W'(2);
            burst_o.frame_end = 1'b1;
            in_frame_d        = 1'b0;
          end
          left_d = left_dec;
        end
      end
      default: begin
        burst_o = '0;
      end
    endcase
  end

  // Frame state, updated only when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q    <= '0;
      sum_b_q    <= '0;
      left_q     <= '0;
      in_frame_q <= 1'b0;
    end else if (accept_i) begin
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      left_q     <= left_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/ubx_frame_builder_unit.sv =====
// UBX frame builder. Each accepted item is turned into its burst of output
// bytes in the cycle it is accepted, and the burst is held in a single burst
// buffer that feeds the output one byte per cycle while the output does not
// stall. A payload item inside a frame gives one byte (three at the end of a
// frame, with CK_A and CK_B), a start item six bytes (eight when the length
// is zero), and a payload item outside a frame gives none. The next item is
// accepted in the cycle the last byte of the current burst is taken, so
// payload items flow at one per cycle while the output does not stall, and a
// start item holds off the next item until its whole burst has been taken.
`default_nettype none
module ubx_frame_builder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  msg_class_i,
  input  wire logic [7:0]  msg_ident_i,
  input  wire logic [15:0] payload_len_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             frame_last_o
);

  ubx_fb_pkg::burst_t                      burst;
  logic                                    in_accept;
  logic                                    out_take;
  logic                                    at_last;

  logic                                    busy_q;
  logic [ubx_fb_pkg::IDX_W-1:0]            idx_q;
  logic [ubx_fb_pkg::IDX_W-1:0]            last_idx_q;
  logic                                    frame_end_q;
  logic [ubx_fb_pkg::BURST_MAX-1:0][7:0]   bytes_q;

  ubx_fb_frame_gen u_frame_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .op_i          (op_i),
    .msg_class_i   (msg_class_i),
    .msg_ident_i   (msg_ident_i),
    .payload_len_i (payload_len_i),
    .data_byte_i   (data_byte_i),
    .burst_o       (burst)
  );

  // Handshake: a new item may enter as the last byte of the burst leaves.
  assign at_last    = (idx_q == last_idx_q);
  assign out_take   = busy_q && !out_stall_i;
  assign in_stall_o = busy_q && !(out_take && at_last);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Output byte selection from the burst buffer.
  assign out_valid_o  = busy_q;
  assign out_byte_o   = bytes_q[idx_q];
  assign run_last_o   = at_last;
  assign frame_last_o = at_last && frame_end_q;

  // Burst buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_accept && burst.emits) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_take) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + ubx_fb_pkg::IDX_W'(1);
      end
    end
  end

  // Burst buffer payload.
  always_ff @(posedge clk_i) begin
    if (in_accept && burst.emits) begin
      bytes_q     <= burst.bytes;
      last_idx_q  <= burst.last_idx;
      frame_end_q <= burst.frame_end;
    end
  end

endmodule
`default_nettype wire

// ===== src/ubx_fb_checker.sv =====
`default_nettype none
module ubx_fb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        op_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        run_last_o,
  input wire logic        frame_last_o
);

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(frame_last_o))
    else $error("stalled output item changed");

  // The end of a frame is always the end of a burst.
  a_frame_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> run_last_o)
    else $error("frame end without burst end");

  // A start item opens its burst with the first sync byte.
  a_start_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == ubx_fb_pkg::OP_START
      |=> out_valid_o && out_byte_o == ubx_fb_pkg::SYNC_ONE && !run_last_o)
    else $error("start item did not open with sync");

  // A burst carries on until its last byte is taken.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("burst broke off early");

  // No new item is taken while the current burst has bytes after this one.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> in_stall_o)
    else $error("item accepted in the middle of a burst");

endmodule

bind ubx_frame_builder_unit ubx_fb_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .run_last_o    (run_last_o),
  .frame_last_o  (frame_last_o)
);
`default_nettype wire
